FILE: rtl/core/lfd_pkg.sv
`timescale 1ns / 1ps

package lfd_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_LABEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COPY_LENGTH  = 3'd4;

    // Register values after reset.
    localparam logic [7:0]  START_CODE_RST   = 8'd126;
    localparam logic [7:0]  END_CODE_RST     = 8'd231;
    localparam logic [7:0]  WANTED_LABEL_RST = 8'd3;
    localparam logic [15:0] MAX_LENGTH_RST   = 16'd600;
    localparam logic [15:0] COPY_LENGTH_RST  = 16'd600;

    // Input request kinds.
    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    // Result kinds.
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Frame completion status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_TOOLONG = 2'd2;
    localparam logic [1:0] ST_BADEND  = 2'd3;

    typedef struct packed {
        logic [7:0]  start_code;
        logic [7:0]  stop_code;
        logic [7:0]  wanted_label;
        logic [15:0] max_length;
        logic [15:0] copy_length;
    } t_cfg;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  out_byte;
        logic [1:0]  status;
        logic [15:0] frame_length;
    } t_result;

endpackage

FILE: rtl/core/lfd_rx_if.sv
`timescale 1ns / 1ps

interface lfd_rx_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

FILE: rtl/core/lfd_res_if.sv
`timescale 1ns / 1ps

interface lfd_res_if;
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic [15:0] frame_length;

    modport source (output valid, output out_kind, output out_byte, output status,
                    output frame_length, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input status,
                    input frame_length, output ready);
endinterface

FILE: rtl/core/lfd_cfg_regs.sv
`timescale 1ns / 1ps

module lfd_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lfd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lfd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output lfd_pkg::t_cfg                   o_cfg
);

    lfd_pkg::t_cfg r_cfg;
    lfd_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lfd_pkg::CFG_START_CODE:   n_cfg.start_code   = i_cfg_data[7:0];
                lfd_pkg::CFG_END_CODE:     n_cfg.stop_code    = i_cfg_data[7:0];
                lfd_pkg::CFG_WANTED_LABEL: n_cfg.wanted_label = i_cfg_data[7:0];
                lfd_pkg::CFG_MAX_LENGTH:   n_cfg.max_length   = i_cfg_data;
                lfd_pkg::CFG_COPY_LENGTH:  n_cfg.copy_length  = i_cfg_data;
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_code   <= lfd_pkg::START_CODE_RST;
            r_cfg.stop_code    <= lfd_pkg::END_CODE_RST;
            r_cfg.wanted_label <= lfd_pkg::WANTED_LABEL_RST;
            r_cfg.max_length   <= lfd_pkg::MAX_LENGTH_RST;
            r_cfg.copy_length  <= lfd_pkg::COPY_LENGTH_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/lfd_frame_fsm.sv
`timescale 1ns / 1ps

module lfd_frame_fsm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lfd_pkg::t_cfg     i_cfg,
    input  logic              i_rx_valid,
    input  logic              i_req_type,
    input  logic [7:0]        i_rx_byte,
    output logic              o_rx_ready,
    input  logic              i_res_space,
    output logic              o_res_load,
    output lfd_pkg::t_result  o_res
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_LABEL   = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_LEN_HI  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_END     = 3'd5;

    // Input register.
    logic       r_item_vld;
    logic       r_req_type;
    logic [7:0] r_rx_byte;

    // Frame state.
    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_len,   n_len;
    logic [15:0] r_seen,  n_seen;

    logic             advance;
    logic             res_hit;
    logic [15:0]      seen_inc;
    logic [15:0]      hdr_len;
    lfd_pkg::t_result res;

    // The registered item moves on whenever the result register can take it.
    assign advance    = r_item_vld && i_res_space;
    assign o_rx_ready = !r_item_vld || advance;

    assign seen_inc = r_seen + 16'd1;
    assign hdr_len  = {r_rx_byte, r_len[7:0]};

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_seen  = r_seen;
        res_hit = 1'b0;
        res     = '0;
        if (r_req_type == lfd_pkg::REQ_TIMEOUT) begin
            res_hit          = 1'b1;
            res.out_kind     = lfd_pkg::KIND_STATUS;
            res.status       = lfd_pkg::ST_TIMEOUT;
            res.frame_length = (r_phase == PH_PAYLOAD || r_phase == PH_END) ? r_len : 16'd0;
            n_phase          = PH_HUNT;
            n_len            = 16'd0;
            n_seen           = 16'd0;
        end else begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (r_rx_byte == i_cfg.start_code) begin
                        n_phase = PH_LABEL;
                    end
                end
                PH_LABEL: begin
                    // A matching label wins even when it equals the start code.
                    if (r_rx_byte == i_cfg.wanted_label) begin
                        n_phase = PH_LEN_LO;
                    end else if (r_rx_byte != i_cfg.start_code) begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_LEN_LO: begin
                    n_len   = {8'd0, r_rx_byte};
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_seen = 16'd0;
                    if (hdr_len > i_cfg.max_length) begin
                        res_hit          = 1'b1;
                        res.out_kind     = lfd_pkg::KIND_STATUS;
                        res.status       = lfd_pkg::ST_TOOLONG;
                        res.frame_length = hdr_len;
                        n_phase          = PH_HUNT;
                        n_len            = 16'd0;
                    end else begin
                        n_len   = hdr_len;
                        n_phase = (hdr_len == 16'd0) ? PH_END : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_seen < i_cfg.copy_length) begin
                        res_hit          = 1'b1;
                        res.out_kind     = lfd_pkg::KIND_BYTE;
                        res.out_byte     = r_rx_byte;
                        res.status       = lfd_pkg::ST_OK;
                        res.frame_length = r_len;
                    end
                    n_seen = seen_inc;
                    if (seen_inc >= r_len) begin
                        n_phase = PH_END;
                    end
                end
                PH_END: begin
                    res_hit          = 1'b1;
                    res.out_kind     = lfd_pkg::KIND_STATUS;
                    res.status       = (r_rx_byte == i_cfg.stop_code) ? lfd_pkg::ST_OK
                                                                       : lfd_pkg::ST_BADEND;
                    res.frame_length = r_len;
                    n_phase          = PH_HUNT;
                    n_len            = 16'd0;
                    n_seen           = 16'd0;
                end
                default: begin
                    n_phase = PH_HUNT;
                    n_len   = 16'd0;
                    n_seen  = 16'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_phase    <= PH_HUNT;
            r_len      <= 16'd0;
            r_seen     <= 16'd0;
        end else begin
            if (o_rx_ready) begin
                r_item_vld <= i_rx_valid;
            end
            if (advance) begin
                r_phase <= n_phase;
                r_len   <= n_len;
                r_seen  <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_req_type <= i_req_type;
            r_rx_byte  <= i_rx_byte;
        end
    end

    assign o_res_load = advance && res_hit;
    assign o_res      = res;

endmodule

FILE: rtl/core/lfd_out_stage.sv
`timescale 1ns / 1ps

module lfd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  lfd_pkg::t_result  i_res,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output lfd_pkg::t_result  o_res
);

    logic             r_vld;
    lfd_pkg::t_result r_res;

    // Room for a new result when empty or when the held one leaves this cycle.
    assign o_space = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_space) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_vld;
    assign o_res   = r_res;

endmodule

FILE: rtl/core/labelled_frame_deframer.sv
`timescale 1ns / 1ps
// A beat accepted on i_rx passes the input register, then the result register, to
// reach o_res; beats that cause no result are simply consumed. Throughput: one rx
// beat per cycle unless o_res stalls, set by the single frame state update per cycle.
// Reset: i_rst_n is synchronous and active low; it empties both pipeline registers,
// returns the parser to start-code hunting and each config register to its default.

module labelled_frame_deframer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lfd_rx_if.sink                          i_rx,
    lfd_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [lfd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lfd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // The frame format is: start code, label, length low byte, length high byte,
    // payload, end code. Leading payload bytes are forwarded as tentative beats
    // as they arrive; the closing status beat tells whether they are good.

    lfd_pkg::t_cfg    cfg;
    lfd_pkg::t_result fsm_res;
    lfd_pkg::t_result out_res;
    logic             res_load;
    logic             res_space;
    logic             res_valid;

    // Register file. Writes are expected only while the block is idle, so the
    // parser always sees a consistent set of values.
    lfd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Input register plus the frame parser. The parser advances one rx beat per
    // cycle whenever the result register has room for whatever that beat yields.
    lfd_frame_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_rx_valid  (i_rx.valid),
        .i_req_type  (i_rx.req_type),
        .i_rx_byte   (i_rx.rx_byte),
        .o_rx_ready  (i_rx.ready),
        .i_res_space (res_space),
        .o_res_load  (res_load),
        .o_res       (fsm_res)
    );

    // Result register. While it holds a stalled result the parser waits, even
    // for beats that produce nothing, and resumes in the cycle the result leaves.
    lfd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_load),
        .i_res   (fsm_res),
        .o_space (res_space),
        .o_valid (res_valid),
        .i_ready (o_res.ready),
        .o_res   (out_res)
    );

    assign o_res.valid        = res_valid;
    assign o_res.out_kind     = out_res.out_kind;
    assign o_res.out_byte     = out_res.out_byte;
    assign o_res.status       = out_res.status;
    assign o_res.frame_length = out_res.frame_length;

endmodule

FILE: rtl/core/lfd_checker.sv
`timescale 1ns / 1ps

module lfd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    input  logic        i_rx_ready,
    input  logic        i_req_type,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic        i_out_kind,
    input  logic [7:0]  i_out_byte,
    input  logic [1:0]  i_status,
    input  logic [15:0] i_frame_length
);

    // A result beat stays offered until it is taken.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> i_res_valid)
        else $error("result beat withdrawn before it was taken");

    // A stalled result beat keeps its payload.
    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> ($stable(i_out_kind) && $stable(i_out_byte)
            && $stable(i_status) && $stable(i_frame_length)))
        else $error("stalled result beat changed");

    // Nothing is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result beat offered after reset");

    // An accepted timeout yields a timeout status beat when parsed with the output open.
    a_timeout_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rx_valid && i_rx_ready && i_req_type == lfd_pkg::REQ_TIMEOUT) ##1 i_res_ready
            |=> (i_res_valid && i_out_kind == lfd_pkg::KIND_STATUS
                 && i_status == lfd_pkg::ST_TIMEOUT))
        else $error("timeout did not produce a timeout status beat");

endmodule

bind labelled_frame_deframer lfd_checker u_lfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rx_valid     (i_rx.valid),
    .i_rx_ready     (i_rx.ready),
    .i_req_type     (i_rx.req_type),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_out_kind     (o_res.out_kind),
    .i_out_byte     (o_res.out_byte),
    .i_status       (o_res.status),
    .i_frame_length (o_res.frame_length)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

typedef enum logic [2:0] {
    P_HUNT,
    P_LABEL,
    P_LEN_LO,
    P_LEN_HI,
    P_PAYLOAD,
    P_END
} parse_phase_e;

// Shadow of the deframer: register copies, parser state and the result beats
// still owed by the block, oldest first.
class frame_tracker;
    lfd_pkg::t_cfg    cfg;
    parse_phase_e     parse_phase;
    logic [15:0]      length_field;
    logic [15:0]      payload_count;
    lfd_pkg::t_result expected_q[$];
    int               mismatches;

    function new();
        cfg.start_code   = lfd_pkg::START_CODE_RST;
        cfg.stop_code    = lfd_pkg::END_CODE_RST;
        cfg.wanted_label = lfd_pkg::WANTED_LABEL_RST;
        cfg.max_length   = lfd_pkg::MAX_LENGTH_RST;
        cfg.copy_length  = lfd_pkg::COPY_LENGTH_RST;
        mismatches       = 0;
        restart();
    endfunction

    function void restart();
        parse_phase   = P_HUNT;
        length_field  = 16'd0;
        payload_count = 16'd0;
    endfunction

    function void set_reg(input logic [lfd_pkg::CFG_IDX_W-1:0] idx,
                          input logic [lfd_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            lfd_pkg::CFG_START_CODE:   cfg.start_code   = data[7:0];
            lfd_pkg::CFG_END_CODE:     cfg.stop_code    = data[7:0];
            lfd_pkg::CFG_WANTED_LABEL: cfg.wanted_label = data[7:0];
            lfd_pkg::CFG_MAX_LENGTH:   cfg.max_length   = data;
            lfd_pkg::CFG_COPY_LENGTH:  cfg.copy_length  = data;
            default: ;
        endcase
    endfunction

    function void push_status(input logic [1:0] st, input logic [15:0] len);
        lfd_pkg::t_result r;
        r              = '0;
        r.out_kind     = lfd_pkg::KIND_STATUS;
        r.status       = st;
        r.frame_length = len;
        expected_q.insert(expected_q.size(), r);
    endfunction

    // Advance the parser by one accepted beat and queue whatever it owes.
    function void note_input(input logic kind, input logic [7:0] data);
        lfd_pkg::t_result r;
        if (kind == lfd_pkg::REQ_TIMEOUT) begin
            push_status(lfd_pkg::ST_TIMEOUT,
                        (parse_phase == P_PAYLOAD || parse_phase == P_END) ?
                        length_field : 16'd0);
            restart();
            return;
        end
        case (parse_phase)
            P_HUNT: begin
                if (data == cfg.start_code)
                    parse_phase = P_LABEL;
            end
            P_LABEL: begin
                // The label match wins even when the label equals the start code.
                if (data == cfg.wanted_label)
                    parse_phase = P_LEN_LO;
                else if (data != cfg.start_code)
                    parse_phase = P_HUNT;
            end
            P_LEN_LO: begin
                length_field = {8'h00, data};
                parse_phase  = P_LEN_HI;
            end
            P_LEN_HI: begin
                length_field[15:8] = data;
                payload_count      = 16'd0;
                if (length_field > cfg.max_length) begin
                    push_status(lfd_pkg::ST_TOOLONG, length_field);
                    restart();
                end else begin
                    parse_phase = (length_field == 16'd0) ? P_END : P_PAYLOAD;
                end
            end
            P_PAYLOAD: begin
                if (payload_count < cfg.copy_length) begin
                    r              = '0;
                    r.out_kind     = lfd_pkg::KIND_BYTE;
                    r.out_byte     = data;
                    r.status       = lfd_pkg::ST_OK;
                    r.frame_length = length_field;
                    expected_q.insert(expected_q.size(), r);
                end
                payload_count = payload_count + 16'd1;
                if (payload_count >= length_field)
                    parse_phase = P_END;
            end
            P_END: begin
                push_status((data == cfg.stop_code) ? lfd_pkg::ST_OK : lfd_pkg::ST_BADEND,
                            length_field);
                restart();
            end
            default: restart();
        endcase
    endfunction

    function void check_result(input lfd_pkg::t_result got);
        lfd_pkg::t_result want;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: kind %0d byte %02h status %0d length %0d",
                         got.out_kind, got.out_byte, got.status, got.frame_length);
            return;
        end
        want = expected_q.pop_front();
        if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
            got.status !== want.status || got.frame_length !== want.frame_length) begin
            mismatches++;
            if (mismatches <= 10) begin
                $write("result mismatch: expected kind %0d byte %02h status %0d length %0d,",
                       want.out_kind, want.out_byte, want.status, want.frame_length);
                $display(" got kind %0d byte %02h status %0d length %0d",
                         got.out_kind, got.out_byte, got.status, got.frame_length);
            end
        end
    endfunction
endclass

module tb_top;

    // Wait after the last predicted result; it covers any beat that is still in
    // the pipeline without owing a result.
    localparam int SETTLE_CYCLES = 8;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [lfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [lfd_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           sink_ready = 1'b0;

    // While set, neither side idles.
    bit steady = 1'b0;
    int beats_sent = 0;

    frame_tracker tracker;

    lfd_rx_if  rx_bus ();
    lfd_res_if res_bus ();

    assign res_bus.ready = sink_ready;

    labelled_frame_deframer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_bus),
        .o_res      (res_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // The result side stalls on roughly one edge in five unless the run is in
    // its steady stretch.
    always @(posedge i_clk) begin
        sink_ready <= steady || ($urandom_range(99) >= 20);
    end

    // Every accepted result beat is checked against the oldest prediction.
    always @(posedge i_clk) begin
        lfd_pkg::t_result got;
        if (i_rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            got.out_kind     = res_bus.out_kind;
            got.out_byte     = res_bus.out_byte;
            got.status       = res_bus.status;
            got.frame_length = res_bus.frame_length;
            tracker.check_result(got);
        end
    end

    // Present one beat and hold it until the block takes it. A random gap may
    // come first; valid stays high from beat to beat otherwise.
    // The prediction is made here, at the accepting edge, so that the traffic
    // generator always sees the parser state that follows the beat.
    task automatic send_beat(input logic kind, input logic [7:0] data);
        if (!steady && $urandom_range(99) < 20) begin
            rx_bus.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        rx_bus.valid    <= 1'b1;
        rx_bus.req_type <= kind;
        rx_bus.rx_byte  <= data;
        @(posedge i_clk);
        while (rx_bus.ready !== 1'b1)
            @(posedge i_clk);
        tracker.note_input(kind, data);
        beats_sent++;
    endtask

    // A frame as it appears on the line: start code, optional repeated start
    // codes, label, length low and high, payload, end code. A length beyond
    // the limit stops after the header, as the block does. At position cut_at
    // a timeout replaces the beat and the frame is abandoned.
    task automatic send_frame(input logic [7:0] label, input logic [15:0] len,
                              input int extra_starts, input int cut_at, input bit good_end);
        int last;
        logic [7:0] b;
        last = (len > tracker.cfg.max_length) ? 3 : 4 + int'(len);
        for (int k = 0; k <= last; k++) begin
            if (k == cut_at) begin
                send_beat(lfd_pkg::REQ_TIMEOUT, 8'($urandom));
                return;
            end
            if (k == 0)
                b = tracker.cfg.start_code;
            else if (k == 1)
                b = label;
            else if (k == 2)
                b = len[7:0];
            else if (k == 3)
                b = len[15:8];
            else if (k < last)
                b = 8'($urandom);
            else if (good_end)
                b = tracker.cfg.stop_code;
            else
                b = tracker.cfg.stop_code ^ 8'($urandom_range(255, 1));
            send_beat(lfd_pkg::REQ_BYTE, b);
            if (k == 0)
                repeat (extra_starts) send_beat(lfd_pkg::REQ_BYTE, tracker.cfg.start_code);
        end
    endtask

    // Mostly short lengths that pass the limit, some just above it, and some
    // with a random high byte, which are too long whenever the limit is small.
    function automatic logic [15:0] pick_length();
        logic [15:0] cap;
        int r;
        cap = (tracker.cfg.max_length < 16'd24) ? tracker.cfg.max_length : 16'd24;
        r   = $urandom_range(99);
        if (r < 75 || tracker.cfg.max_length == 16'hFFFF)
            return 16'($urandom_range(int'(cap), 0));
        if (r < 90 || tracker.cfg.max_length >= 16'd256)
            return tracker.cfg.max_length + 16'd1;
        return 16'($urandom_range(65535, 256));
    endfunction

    // Random traffic: well-formed frames with random content make up most of
    // it; the rest are frames cut by a timeout, frames with a random label,
    // stray bytes and lone timeouts. A frame that would start while the parser
    // is still inside an earlier one is preceded by a timeout to bring it back
    // to hunting.
    task automatic run_traffic(input int count);
        int stop_at;
        int r;
        int cut;
        logic [15:0] len;
        stop_at = beats_sent + count;
        while (beats_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 85) begin
                if (tracker.parse_phase != P_HUNT)
                    send_beat(lfd_pkg::REQ_TIMEOUT, 8'($urandom));
                len = pick_length();
                cut = -1;
                if (r >= 70 && r < 78)
                    cut = int'($urandom_range(4 + int'(len), 1));
                send_frame((r < 78) ? tracker.cfg.wanted_label : 8'($urandom), len,
                           ($urandom_range(9) == 0) ? int'($urandom_range(2, 1)) : 0,
                           cut, $urandom_range(9) != 0);
            end else if (r < 92) begin
                repeat ($urandom_range(4, 1)) send_beat(lfd_pkg::REQ_BYTE, 8'($urandom));
            end else begin
                send_beat(lfd_pkg::REQ_TIMEOUT, 8'($urandom));
            end
        end
    endtask

    // Stop sending and wait until every predicted result has come back, then
    // let the pipeline drain of beats that owe nothing.
    task automatic settle();
        rx_bus.valid <= 1'b0;
        while (tracker.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the enable stays high across back-to-back writes.
    task automatic put_reg(input logic [lfd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lfd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.set_reg(idx, data);
    endtask

    task automatic load_settings(input logic [7:0] start_code, input logic [7:0] stop_code,
                                 input logic [7:0] label, input logic [15:0] max_length,
                                 input logic [15:0] copy_length);
        put_reg(lfd_pkg::CFG_START_CODE, {8'h00, start_code});
        put_reg(lfd_pkg::CFG_END_CODE, {8'h00, stop_code});
        put_reg(lfd_pkg::CFG_WANTED_LABEL, {8'h00, label});
        put_reg(lfd_pkg::CFG_MAX_LENGTH, max_length);
        put_reg(lfd_pkg::CFG_COPY_LENGTH, copy_length);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        tracker = new();
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= lfd_pkg::CFG_START_CODE;
        i_cfg_data      <= '0;
        rx_bus.valid    <= 1'b0;
        rx_bus.req_type <= lfd_pkg::REQ_BYTE;
        rx_bus.rx_byte  <= 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats under the reset settings. A timeout while hunting
        // reports a zero length.
        send_beat(lfd_pkg::REQ_TIMEOUT, 8'hFF);
        // A clean two-byte frame; the copy limit is far above the length.
        send_frame(lfd_pkg::WANTED_LABEL_RST, 16'd2, 0, -1, 1'b1);
        // A start code where the label belongs restarts the label check; the
        // zero length sends the next beat straight to the end code check,
        // which fails here.
        send_frame(lfd_pkg::WANTED_LABEL_RST, 16'd0, 1, -1, 1'b0);
        // The largest length is rejected at once, before any payload.
        send_frame(lfd_pkg::WANTED_LABEL_RST, 16'hFFFF, 0, -1, 1'b1);
        // A timeout in the middle of the payload reports the header length.
        send_frame(lfd_pkg::WANTED_LABEL_RST, 16'd3, 0, 5, 1'b1);
        // A wrong label drops the parser back to hunting without a result.
        send_beat(lfd_pkg::REQ_BYTE, lfd_pkg::START_CODE_RST);
        send_beat(lfd_pkg::REQ_BYTE, 8'h00);
        settle();

        // Random traffic under a series of settings. The first two put every
        // register at its extremes: the first one has label zero, which is
        // also the start code, no copied bytes and no length limit; the second
        // accepts only empty frames and copies everything. The third keeps the
        // reset codes but copies only the first few payload bytes. The fifth
        // runs without idling on either side. Each setting ends with the
        // sender holding off until every result has arrived.
        for (int setting = 0; setting < 8; setting++) begin
            case (setting)
                0: load_settings(8'h00, 8'hFF, 8'h00, 16'hFFFF, 16'h0000);
                1: load_settings(8'hFF, 8'h00, 8'hFF, 16'h0000, 16'hFFFF);
                2: load_settings(lfd_pkg::START_CODE_RST, lfd_pkg::END_CODE_RST,
                                 lfd_pkg::WANTED_LABEL_RST, lfd_pkg::MAX_LENGTH_RST, 16'd5);
                default: load_settings(8'($urandom), 8'($urandom), 8'($urandom_range(255, 1)),
                                       16'($urandom_range(40, 0)), 16'($urandom_range(30, 0)));
            endcase
            steady = (setting == 4);
            run_traffic(150);
            settle();
        end

        if (tracker.mismatches == 0 && tracker.expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end
endmodule

FILE: labelled_frame_deframer.f
rtl/core/lfd_pkg.sv
rtl/core/lfd_rx_if.sv
rtl/core/lfd_res_if.sv
rtl/core/lfd_cfg_regs.sv
rtl/core/lfd_frame_fsm.sv
rtl/core/lfd_out_stage.sv
rtl/core/labelled_frame_deframer.sv
rtl/core/lfd_checker.sv
verif/tb_top.sv
